// ===== rtl/kcl_pkg.sv =====
// Shared types and codes for the keypad code lock.
`timescale 1ns / 1ps
package kcl_pkg;

	typedef struct packed {
		logic       kind;
		logic [3:0] key_code;
	} in_t;

	typedef struct packed {
		logic [3:0] event_res;
		logic [1:0] motor_cmd;
		logic       is_locked;
		logic [2:0] mode_now;
		logic [3:0] entered_count;
		logic       reveal_on;
	} out_t;

	localparam logic KIND_KEY  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [3:0] KEY_A    = 4'd3;
	localparam logic [3:0] KEY_STAR = 4'd12;
	localparam logic [3:0] KEY_HASH = 4'd14;

	localparam logic [2:0] M_LOCKED  = 3'd0;
	localparam logic [2:0] M_OPEN    = 3'd1;
	localparam logic [2:0] M_VERIFY  = 3'd2;
	localparam logic [2:0] M_NEW     = 3'd3;
	localparam logic [2:0] M_CONFIRM = 3'd4;

	localparam logic [3:0] EV_NONE     = 4'd0;
	localparam logic [3:0] EV_BOUNCED  = 4'd1;
	localparam logic [3:0] EV_DIGIT    = 4'd2;
	localparam logic [3:0] EV_CLEARED  = 4'd3;
	localparam logic [3:0] EV_GRANTED  = 4'd4;
	localparam logic [3:0] EV_DENIED   = 4'd5;
	localparam logic [3:0] EV_RELOCKED = 4'd6;
	localparam logic [3:0] EV_CHG_START = 4'd7;
	localparam logic [3:0] EV_OLD_OK   = 4'd8;
	localparam logic [3:0] EV_OLD_BAD  = 4'd9;
	localparam logic [3:0] EV_CANCEL   = 4'd10;
	localparam logic [3:0] EV_NEW_TAKEN = 4'd11;
	localparam logic [3:0] EV_CHANGED  = 4'd12;
	localparam logic [3:0] EV_MISMATCH = 4'd13;
	localparam logic [3:0] EV_REVEAL   = 4'd14;
	localparam logic [3:0] EV_EXPIRED  = 4'd15;

	localparam logic [1:0] MOTOR_NONE  = 2'd0;
	localparam logic [1:0] MOTOR_OPEN  = 2'd1;
	localparam logic [1:0] MOTOR_CLOSE = 2'd2;

	localparam logic CFG_DEBOUNCE = 1'b0;
	localparam logic CFG_REVEAL   = 1'b1;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd200;
	localparam logic [15:0] REVEAL_RESET   = 16'd3500;
	localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

	// factory PIN, first four digit slots; the rest reset to zero
	localparam int PIN_RESET_LEN = 4;
	localparam logic [3:0] PIN_RESET [PIN_RESET_LEN] = '{4'd0, 4'd1, 4'd2, 4'd4};

endpackage

// ===== rtl/keypad_code_lock.sv =====
// Keypad PIN lock with PIN change, debounce and reveal timer.
//
// channel | dir | handshake        | beat
// in      | in  | in_valid/in_stall | in_t: kind, key_code
// out     | out | out_valid/out_stall | out_t: event, motor, status
// cfg     | in  | cfg_we           | cfg_index selects debounce or reveal ticks
//
// One item per cycle while the output is not stalled: an input register feeds
// the state update and result logic, which loads the output register.
// The state update (two parallel PIN compares) sets the cycle.
// Reset loads the factory PIN and default tick counts; no clearing pass.
// A stalled output holds the result; the input register refills behind it
// and in_stall rises only when both are full.
`timescale 1ns / 1ps
module keypad_code_lock
	import kcl_pkg::*;
#(
	parameter int MAX_DIGITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int LW = $clog2(MAX_DIGITS + 1);
	localparam int IW = $clog2(MAX_DIGITS);
	localparam logic [LW-1:0] LEN_MAX = LW'(MAX_DIGITS);

	// input register
	logic        valid_s1;
	in_t         item_s1;
	logic        advance;

	// result register
	logic        out_valid_q;
	out_t        out_data_q;

	// configuration
	logic [15:0] debounce_q;
	logic [15:0] reveal_ticks_q;

	// lock state
	logic [2:0]    mode_q;
	logic [3:0]    stored_q [MAX_DIGITS];
	logic [LW-1:0] stored_len_q;
	logic [3:0]    entry_q [MAX_DIGITS];
	logic [LW-1:0] entry_len_q;
	logic [3:0]    cand_q [MAX_DIGITS];
	logic [LW-1:0] cand_len_q;
	logic          reveal_q;
	logic [15:0]   reveal_timer_q;
	logic [15:0]   since_key_q;

	// next state
	logic [2:0]    mode_d;
	logic [LW-1:0] stored_len_d;
	logic [LW-1:0] entry_len_d;
	logic [LW-1:0] cand_len_d;
	logic          reveal_d;
	logic [15:0]   reveal_timer_d;
	logic [15:0]   since_key_d;
	logic          digit_we;
	logic          cand_we;
	logic          stored_we;
	logic [3:0]    ev;
	logic [1:0]    motor;
	logic          match_stored;
	logic          match_cand;
	logic [LW+3:0] count_ext;
	out_t          result;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= DEBOUNCE_RESET;
			reveal_ticks_q <= REVEAL_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_DEBOUNCE) begin
				debounce_q <= cfg_data;
			end else begin
				reveal_ticks_q <= cfg_data;
			end
		end
	end

	// digit-wise compares, only slots below the entry length count
	always_comb begin
		match_stored = (entry_len_q == stored_len_q);
		match_cand   = (entry_len_q == cand_len_q);
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (LW'(i) < entry_len_q) begin
				if (entry_q[i] != stored_q[i]) match_stored = 1'b0;
				if (entry_q[i] != cand_q[i])   match_cand = 1'b0;
			end
		end
	end

	always_comb begin
		mode_d         = mode_q;
		stored_len_d   = stored_len_q;
		entry_len_d    = entry_len_q;
		cand_len_d     = cand_len_q;
		reveal_d       = reveal_q;
		reveal_timer_d = reveal_timer_q;
		since_key_d    = since_key_q;
		digit_we       = 1'b0;
		cand_we        = 1'b0;
		stored_we      = 1'b0;
		ev             = EV_NONE;
		motor          = MOTOR_NONE;

		if (item_s1.kind == KIND_TICK) begin
			if (since_key_q != COUNT_MAX) since_key_d = since_key_q + 16'd1;
			if (reveal_q) begin
				if (reveal_timer_q != COUNT_MAX) reveal_timer_d = reveal_timer_q + 16'd1;
				if (reveal_timer_d > reveal_ticks_q) begin
					reveal_d = 1'b0;
					ev       = EV_EXPIRED;
				end
			end
		end else if (since_key_q <= debounce_q) begin
			ev = EV_BOUNCED;
		end else begin
			since_key_d = 16'd0;
			case (mode_q)
				M_LOCKED, M_VERIFY: begin
					if (item_s1.key_code == KEY_HASH) begin
						entry_len_d = '0;
						if (mode_q == M_LOCKED) begin
							ev = EV_CLEARED;
						end else begin
							mode_d = M_OPEN;
							ev     = EV_CANCEL;
						end
					end else if (item_s1.key_code == KEY_A) begin
						reveal_d = !reveal_q;
						if (!reveal_q) reveal_timer_d = 16'd0;
						ev = EV_REVEAL;
					end else if (item_s1.key_code == KEY_STAR) begin
						entry_len_d = '0;
						if (match_stored) begin
							reveal_d = 1'b0;
							if (mode_q == M_LOCKED) begin
								mode_d = M_OPEN;
								motor  = MOTOR_OPEN;
								ev     = EV_GRANTED;
							end else begin
								mode_d = M_NEW;
								ev     = EV_OLD_OK;
							end
						end else begin
							ev = (mode_q == M_LOCKED) ? EV_DENIED : EV_OLD_BAD;
						end
					end else if (entry_len_q < LEN_MAX) begin
						digit_we    = 1'b1;
						entry_len_d = entry_len_q + LW'(1);
						ev          = EV_DIGIT;
					end
				end
				M_OPEN: begin
					if (item_s1.key_code == KEY_HASH) begin
						mode_d = M_LOCKED;
						motor  = MOTOR_CLOSE;
						ev     = EV_RELOCKED;
					end else if (item_s1.key_code == KEY_STAR) begin
						mode_d      = M_VERIFY;
						entry_len_d = '0;
						ev          = EV_CHG_START;
					end
				end
				default: begin
					// enter new and confirm new
					if (item_s1.key_code == KEY_HASH) begin
						mode_d      = M_OPEN;
						entry_len_d = '0;
						if (mode_q != M_NEW) cand_len_d = '0;
						ev = EV_CANCEL;
					end else if (item_s1.key_code == KEY_STAR) begin
						entry_len_d = '0;
						if (mode_q == M_NEW) begin
							cand_we    = 1'b1;
							cand_len_d = entry_len_q;
							mode_d     = M_CONFIRM;
							ev         = EV_NEW_TAKEN;
						end else if (match_cand) begin
							stored_we    = 1'b1;
							stored_len_d = cand_len_q;
							cand_len_d   = '0;
							mode_d       = M_OPEN;
							ev           = EV_CHANGED;
						end else begin
							mode_d = M_NEW;
							ev     = EV_MISMATCH;
						end
					end else if (entry_len_q < LEN_MAX) begin
						digit_we    = 1'b1;
						entry_len_d = entry_len_q + LW'(1);
						ev          = EV_DIGIT;
					end
				end
			endcase
		end
	end

	always_comb begin
		count_ext            = {4'd0, entry_len_d};
		result.event_res     = ev;
		result.motor_cmd     = motor;
		result.is_locked     = (mode_d == M_LOCKED);
		result.mode_now      = mode_d;
		result.entered_count = count_ext[3:0];
		result.reveal_on     = reveal_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= M_LOCKED;
			stored_len_q   <= LW'(PIN_RESET_LEN);
			entry_len_q    <= '0;
			cand_len_q     <= '0;
			reveal_q       <= 1'b0;
			reveal_timer_q <= 16'd0;
			since_key_q    <= COUNT_MAX;
			for (int i = 0; i < PIN_RESET_LEN; i++) begin
				stored_q[i] <= PIN_RESET[i];
			end
			for (int i = PIN_RESET_LEN; i < MAX_DIGITS; i++) begin
				stored_q[i] <= 4'd0;
			end
		end else if (advance) begin
			mode_q         <= mode_d;
			stored_len_q   <= stored_len_d;
			entry_len_q    <= entry_len_d;
			cand_len_q     <= cand_len_d;
			reveal_q       <= reveal_d;
			reveal_timer_q <= reveal_timer_d;
			since_key_q    <= since_key_d;
			if (stored_we) begin
				stored_q <= cand_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (digit_we) begin
				entry_q[entry_len_q[IW-1:0]] <= item_s1.key_code;
			end
			if (cand_we) begin
				cand_q <= entry_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	a_open_only_granted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.motor_cmd == MOTOR_OPEN
		|-> out_data.event_res == EV_GRANTED && out_data.mode_now == M_OPEN)
		else $error("open command without a granted PIN");

	a_entry_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		entry_len_q <= LEN_MAX && cand_len_q <= LEN_MAX)
		else $error("digit count past capacity");

	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("waiting item dropped from input register");

	a_reveal_by_key: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(reveal_q) |-> $past(advance && item_s1.kind == KIND_KEY))
		else $error("reveal flag set without a key beat");

endmodule
